// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the matcher RTL (ism_tally); empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every rising clock edge outside reset.
`define ISM_ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("property check failed");

// Check that a condition never holds at a rising clock edge outside reset.
`define ISM_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ISM_ASSERT_PROP(label, clk, rst_n, prop)
`define ISM_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== design/ism_pkg.sv =====
// ----------------------------------------------------------------------------
// ism_pkg
// Sizes, function codes and shared types of the indeterminate string matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ism_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int ALPHA       = 32;

    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int LETTER_W = 32;
    localparam int LEN_W    = 7;
    localparam int POS_W    = 32;
    localparam int CNT_W    = 32;

    // Width that holds both the length register and any cell number.
    localparam int SPAN_W = ($clog2(PATTERN_MAX + 1) > LEN_W) ?
                            $clog2(PATTERN_MAX + 1) : LEN_W;

    localparam logic [LETTER_W-1:0] ALPHA_MASK = (ALPHA >= LETTER_W) ?
        {LETTER_W{1'b1}} : LETTER_W'((64'd1 << ALPHA) - 64'd1);

    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd1;

    // Broadcast to every cell.
    typedef struct packed {
        logic text;
        logic restart;
    } ism_ctl_t;

    // One accepted item as seen by the result stage.
    typedef struct packed {
        logic              accept;
        logic              text;
        logic              restart;
        logic              hit;
        logic [SPAN_W-1:0] back;
    } ism_step_t;

endpackage

`default_nettype wire

// ===== design/ism_if.sv =====
// ----------------------------------------------------------------------------
// ism_if
// Valid/ready channels of the matcher: items, results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface ism_item_if;
    logic                         valid;
    logic                         ready;
    logic [ism_pkg::FUNC_W-1:0]   func;
    logic [ism_pkg::INDEX_W-1:0]  index;
    logic [ism_pkg::LETTER_W-1:0] letter;

    modport source (output valid, output func, output index, output letter,
                    input ready);
    modport sink   (input valid, input func, input index, input letter,
                    output ready);
endinterface

interface ism_result_if;
    logic                      valid;
    logic                      ready;
    logic                      match_end;
    logic [ism_pkg::POS_W-1:0] match_start;
    logic [ism_pkg::CNT_W-1:0] occurrence_count;

    modport source (output valid, output match_end, output match_start,
                    output occurrence_count, input ready);
    modport sink   (input valid, input match_end, input match_start,
                    input occurrence_count, output ready);
endinterface

interface ism_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [ism_pkg::LEN_W-1:0] pat_len;

    modport source (output valid, output pat_len, input ready);
    modport sink   (input valid, input pat_len, output ready);
endinterface

`default_nettype wire

// ===== design/ism_cell.sv =====
// ----------------------------------------------------------------------------
// ism_cell
// One pattern position: holds its letter and the prefix bit that ends here.
// ----------------------------------------------------------------------------
`default_nettype none

module ism_cell (
    input  wire                         clk,
    input  wire                         rst_n,
    input  ism_pkg::ism_ctl_t           ctl,
    input  wire [ism_pkg::LETTER_W-1:0] letter,
    input  wire                         wr_en,
    input  wire                         enable,
    input  wire                         last,
    input  wire                         prev_bit,
    output logic                        prefix_bit,
    output logic                        tail_hit
);
    import ism_pkg::*;

    logic [LETTER_W-1:0] letter_reg;
    logic                prefix_reg;
    logic                prefix_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            letter_reg <= letter;
        end
    end

    // Extend the prefix from the neighbor when the letters share a symbol.
    assign prefix_next = prev_bit & enable & (|(letter_reg & letter & ALPHA_MASK));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= 1'b0;
        end
        else if (ctl.restart)
        begin
            prefix_reg <= 1'b0;
        end
        else if (ctl.text)
        begin
            prefix_reg <= prefix_next;
        end
    end

    assign prefix_bit = prefix_reg;
    assign tail_hit   = last & prefix_next;

endmodule

`default_nettype wire

// ===== design/ism_tally.sv =====
// ----------------------------------------------------------------------------
// ism_tally
// Text position, saturating occurrence count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ism_tally (
    input  wire                 clk,
    input  wire                 rst_n,
    input  ism_pkg::ism_step_t  step,
    output logic                slot_free,
    ism_result_if.source        results
);
    import ism_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_end_reg;
    logic             out_end_next;
    logic [POS_W-1:0] out_start_reg;
    logic [POS_W-1:0] out_start_next;
    logic [CNT_W-1:0] out_count_reg;

    assign slot_free = !out_valid_reg || results.ready;

    always_comb
    begin
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_end_next   = 1'b0;
        out_start_next = '0;
        if (step.accept)
        begin
            out_valid_next = 1'b1;
            if (step.text)
            begin
                pos_next = pos_reg + POS_W'(1);
                if (step.hit)
                begin
                    if (cnt_reg != {CNT_W{1'b1}})
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    out_end_next   = 1'b1;
                    out_start_next = pos_reg - POS_W'(step.back);
                end
            end
            else if (step.restart)
            begin
                pos_next = '0;
                cnt_next = '0;
            end
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.accept)
        begin
            out_end_reg   <= out_end_next;
            out_start_reg <= out_start_next;
            out_count_reg <= cnt_next;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.match_end        = out_end_reg;
    assign results.match_start      = out_start_reg;
    assign results.occurrence_count = out_count_reg;

    `ISM_ASSERT_NEVER(a_start_without_end, clk, rst_n, results.valid && !results.match_end && (results.match_start != '0))
    `ISM_ASSERT_NEVER(a_end_with_zero_count, clk, rst_n, results.valid && results.match_end && (results.occurrence_count == '0))
    `ISM_ASSERT_PROP(a_restart_clears, clk, rst_n, step.accept && step.restart |=> (pos_reg == '0) && (cnt_reg == '0))
    `ISM_ASSERT_PROP(a_miss_holds_count, clk, rst_n, step.accept && step.text && !step.hit |=> $stable(cnt_reg))

endmodule

`default_nettype wire

// ===== design/indeterminate_string_matcher_core.sv =====
// ----------------------------------------------------------------------------
// indeterminate_string_matcher_core
// Counts occurrences of an indeterminate pattern in a streamed text.
// ----------------------------------------------------------------------------
// Each letter is a set mask over ALPHA symbols; a pattern letter and a text
// letter match when their masks share a set bit. Write the pattern first with
// func WRITE transfers (one letter per index), set pat_len on the cfg
// channel while the block is idle, then stream text with func TEXT transfers;
// func RESTART clears the scan, the position and the count. Every item
// transfer yields exactly one result, presented on the result channel from the
// cycle after the item transfer and held until it is taken: match_end,
// match_start (text position where the occurrence began, zero otherwise) and
// the saturating occurrence count. The block takes one item per cycle, the
// next one while the previous result is still waiting, as long as the result
// register is empty or being drained. That rate is set by the row of
// PATTERN_MAX cells, one per pattern position: for each text letter every cell
// compares its stored letter with the text letter and moves its neighbor's
// prefix bit one place along the row.
// ----------------------------------------------------------------------------
`default_nettype none

module indeterminate_string_matcher_core (
    input  wire          clk,
    input  wire          rst_n,
    ism_item_if.sink     items,
    ism_result_if.source results,
    ism_cfg_if.sink      cfg
);
    import ism_pkg::*;

    logic [LEN_W-1:0]       len_reg;
    logic [SPAN_W-1:0]      len_ext;
    logic [SPAN_W-1:0]      used_len;
    logic [SPAN_W-1:0]      back;
    logic                   accept;
    logic                   slot_free;
    ism_ctl_t               ctl;
    ism_step_t              step;
    logic [PATTERN_MAX-1:0] prefix;
    logic [PATTERN_MAX-1:0] tail;
    logic [PATTERN_MAX-1:0] cell_en;
    logic [PATTERN_MAX-1:0] cell_last;
    logic [PATTERN_MAX-1:0] cell_wr;

    // Configuration is always taken; it lands in the length register.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else if (cfg.valid)
        begin
            len_reg <= cfg.pat_len;
        end
    end

    // Clamp the length into 1..PATTERN_MAX.
    assign len_ext = SPAN_W'(len_reg);

    always_comb
    begin
        if (len_ext == '0)
        begin
            used_len = SPAN_W'(1);
        end
        else if (len_ext > SPAN_W'(PATTERN_MAX))
        begin
            used_len = SPAN_W'(PATTERN_MAX);
        end
        else
        begin
            used_len = len_ext;
        end
    end

    assign back = used_len - SPAN_W'(1);

    // Accept whenever the result register can take the outcome.
    assign items.ready = slot_free;
    assign accept      = items.valid && slot_free;

    assign ctl.text    = accept && (items.func == FUNC_TEXT);
    assign ctl.restart = accept && (items.func == FUNC_RESTART);

    // The row of cells: cell k owns pattern letter k and prefix bit k.
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        logic prev_bit;

        assign cell_en[k]   = SPAN_W'(k) < used_len;
        assign cell_last[k] = SPAN_W'(k) == back;
        assign cell_wr[k]   = accept && (items.func == FUNC_WRITE) &&
                              ((k >> INDEX_W) == 0) &&
                              (items.index == INDEX_W'(k));

        if (k == 0)
        begin : g_head
            assign prev_bit = 1'b1;
        end
        else
        begin : g_link
            assign prev_bit = prefix[k-1];
        end

        ism_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .letter     (items.letter),
            .wr_en      (cell_wr[k]),
            .enable     (cell_en[k]),
            .last       (cell_last[k]),
            .prev_bit   (prev_bit),
            .prefix_bit (prefix[k]),
            .tail_hit   (tail[k])
        );
    end

    // A full occurrence ends here when the last active cell extends its prefix.
    assign step.accept  = accept;
    assign step.text    = ctl.text;
    assign step.restart = ctl.restart;
    assign step.hit     = ctl.text && (|tail);
    assign step.back    = back;

    ism_tally u_tally (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .slot_free (slot_free),
        .results   (results)
    );

endmodule

`default_nettype wire
